// ----- rtl/gdn_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gdn_pkg: shared widths and stage types of the gamepad deadzone normalizer
// Holds the widths of the square-root and division datapaths and the
// per-stage record of one iteration of each.
// ----------------------------------------------------------------------------
package gdn_pkg;

	localparam int SQ_STEPS  = 24;  // root bits of the stick magnitude
	localparam int DIV_STEPS = 16;  // quotient bits of a scaled output
	localparam int SUM_W     = 32;  // x*x + y*y
	localparam int ROOT_W    = 24;  // magnitude with 8 fraction bits
	localparam int REM_W     = 26;  // square-root partial remainder
	localparam int DVD_W     = 55;  // rounded dividend
	localparam int DSH_W     = 54;  // shifted divisor
	localparam int QUO_W     = 16;

	typedef struct packed {
		logic [SUM_W-1:0]  src;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sq_t;

	typedef struct packed {
		logic [DVD_W-1:0] rem;
		logic [DSH_W-1:0] dsh;
		logic [QUO_W-1:0] quo;
	} dv_t;

endpackage
`default_nettype wire

// ----- rtl/gdn_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gdn_in_if: raw gamepad sample channel
// Valid/ready channel carrying buttons, triggers and both stick positions.
// ----------------------------------------------------------------------------
interface gdn_in_if;
	logic               valid;
	logic               ready;
	logic        [15:0] button_bits;
	logic        [7:0]  left_trigger;
	logic        [7:0]  right_trigger;
	logic signed [15:0] left_x;
	logic signed [15:0] left_y;
	logic signed [15:0] right_x;
	logic signed [15:0] right_y;

	modport source (output valid, button_bits, left_trigger, right_trigger,
		left_x, left_y, right_x, right_y, input ready);
	modport sink (input valid, button_bits, left_trigger, right_trigger,
		left_x, left_y, right_x, right_y, output ready);
endinterface
`default_nettype wire

// ----- rtl/gdn_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gdn_out_if: normalized gamepad result channel
// Valid/ready channel carrying buttons, trigger levels and scaled sticks.
// ----------------------------------------------------------------------------
interface gdn_out_if;
	logic               valid;
	logic               ready;
	logic        [15:0] button_bits_out;
	logic        [15:0] left_trigger_level;
	logic        [15:0] right_trigger_level;
	logic signed [15:0] left_x_out;
	logic signed [15:0] left_y_out;
	logic signed [15:0] right_x_out;
	logic signed [15:0] right_y_out;

	modport source (output valid, button_bits_out, left_trigger_level,
		right_trigger_level, left_x_out, left_y_out, right_x_out, right_y_out,
		input ready);
	modport sink (input valid, button_bits_out, left_trigger_level,
		right_trigger_level, left_x_out, left_y_out, right_x_out, right_y_out,
		output ready);
endinterface
`default_nettype wire

// ----- rtl/gdn_sqrt_step.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gdn_sqrt_step: one registered digit of the integer square root
// Brings down two radicand bits and decides one root bit.
// ----------------------------------------------------------------------------
module gdn_sqrt_step (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire gdn_pkg::sq_t d,
	output gdn_pkg::sq_t     q
);
	import gdn_pkg::*;

	logic [REM_W+1:0] cur;
	logic [REM_W+1:0] trial;
	sq_t              nxt;

	always_comb begin
		cur      = {d.rem, d.src[SUM_W-1 -: 2]};
		trial    = {2'b00, d.root, 2'b01};
		nxt.src  = {d.src[SUM_W-3:0], 2'b00};
		if (cur >= trial) begin
			nxt.rem  = REM_W'(cur - trial);
			nxt.root = {d.root[ROOT_W-2:0], 1'b1};
		end else begin
			nxt.rem  = cur[REM_W-1:0];
			nxt.root = {d.root[ROOT_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end
endmodule
`default_nettype wire

// ----- rtl/gdn_div_step.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gdn_div_step: one registered bit of restoring division
// Subtracts the shifted divisor when it fits and shifts it down one place.
// ----------------------------------------------------------------------------
module gdn_div_step (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire gdn_pkg::dv_t d,
	output gdn_pkg::dv_t     q
);
	import gdn_pkg::*;

	logic [DVD_W-1:0] dsh_ext;
	dv_t              nxt;

	always_comb begin
		dsh_ext = {1'b0, d.dsh};
		nxt.dsh = d.dsh >> 1;
		if (dsh_ext <= d.rem) begin
			nxt.rem = d.rem - dsh_ext;
			nxt.quo = {d.quo[QUO_W-2:0], 1'b1};
		end else begin
			nxt.rem = d.rem;
			nxt.quo = {d.quo[QUO_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end
endmodule
`default_nettype wire

// ----- rtl/gamepad_deadzone_normalizer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gamepad_deadzone_normalizer: trigger and radial stick deadzone scaling
// Turns a raw gamepad sample into normalized trigger levels and scaled sticks.
// ----------------------------------------------------------------------------
// Usage:
// Raw samples arrive on pad_in and normalized results leave on pad_out, both
// valid/ready channels; an item moves on an edge where valid and ready are
// both high. Every sample gives exactly one result, in order.
// The pipeline is 46 register stages deep: two stages square the stick axes,
// 24 stages find the magnitude one root bit each, three stages form the
// deadzone scale, 16 stages divide one quotient bit each, and an output
// register holds the result. Samples are taken one per cycle for as long as
// the receiver keeps up with the results.
// A skid register behind the pipeline takes one more result while the
// output waits, so the pipeline stalls as a whole only once both are full;
// no item is dropped or repeated by a stall.
// Reset empties the pipeline and loads the deadzones with 30, 7849 and 8689.
// The deadzone registers are written through cfg_we/cfg_index/cfg_wdata and
// must only change while no item is in flight.
// ----------------------------------------------------------------------------
module gamepad_deadzone_normalizer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	gdn_in_if.sink           pad_in,
	gdn_out_if.source        pad_out,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [14:0] cfg_wdata
);
	import gdn_pkg::*;

	// Register indexes of the configuration port.
	localparam logic [1:0] CFG_TRIG_DZ  = 2'd0;
	localparam logic [1:0] CFG_LEFT_DZ  = 2'd1;
	localparam logic [1:0] CFG_RIGHT_DZ = 2'd2;

	// Pipeline layout: S1 abs/square, S2 sum, sqrt steps, S27 clamp,
	// S28 multiply, S29 dividend setup, division steps.
	localparam int SQ_BASE  = 2;
	localparam int S27      = SQ_BASE + SQ_STEPS;
	localparam int DIV_BASE = S27 + 3;
	localparam int NS       = DIV_BASE + DIV_STEPS;

	localparam logic [ROOT_W-1:0] MAG_CAP    = ROOT_W'(24'd8388352);
	localparam logic [14:0]       STICK_FULL = 15'd32767;
	localparam logic [7:0]        TRIG_FULL  = 8'd255;
	localparam logic [15:0]       AXIS_MAX   = 16'd32767;

	typedef struct packed {
		logic [15:0]      buttons;
		logic [1:0][24:0] tdvd;
		logic [1:0][8:0]  tdsr;
		logic [1:0]       tzero;
		logic [3:0]       ax_neg;
		logic [3:0][15:0] ax_mag;
	} side_t;

	typedef struct packed {
		logic [15:0] buttons;
		logic [5:0]  zero;
		logic [5:0]  neg;
	} tail_t;

	typedef struct packed {
		logic [15:0] buttons;
		logic [15:0] lt;
		logic [15:0] rt;
		logic [15:0] lx;
		logic [15:0] ly;
		logic [15:0] rx;
		logic [15:0] ry;
	} res_t;

	// Configuration registers.
	logic [7:0]  trig_dz_q;
	logic [14:0] left_dz_q;
	logic [14:0] right_dz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_dz_q  <= 8'd30;
			left_dz_q  <= 15'd7849;
			right_dz_q <= 15'd8689;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TRIG_DZ:  trig_dz_q  <= cfg_wdata[7:0];
				CFG_LEFT_DZ:  left_dz_q  <= cfg_wdata;
				CFG_RIGHT_DZ: right_dz_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Flow control: the whole pipeline advances unless the skid register is
	// occupied, which happens only while the output holds a result too.
	logic          en;
	logic [NS-1:0] v_q;
	logic          skid_v_q;
	logic          out_v_q;

	assign en           = !skid_v_q;
	assign pad_in.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[NS-2:0], pad_in.valid};
		end
	end

	// ---------------- S1: deadzone subtraction, magnitudes, squares ------
	side_t            side_c;
	logic [1:0][31:0] xx_c;
	logic [1:0][31:0] yy_c;
	logic [1:0][7:0]  trig_raw;
	logic [3:0][15:0] ax_raw;
	logic [7:0]       tnum;
	logic [7:0]       tden;

	assign trig_raw = {pad_in.right_trigger, pad_in.left_trigger};
	assign ax_raw   = {pad_in.right_y, pad_in.right_x, pad_in.left_y, pad_in.left_x};

	always_comb begin
		tden = TRIG_FULL - trig_dz_q;
		side_c.buttons = pad_in.button_bits;
		for (int i = 0; i < 2; i++) begin
			tnum = trig_raw[i] - trig_dz_q;
			side_c.tzero[i] = (trig_raw[i] <= trig_dz_q);
			// Round to nearest: (num*65535*2 + den) / (2*den).
			side_c.tdvd[i] = {tnum, 17'b0} - 25'({tnum, 1'b0}) + 25'(tden);
			side_c.tdsr[i] = {tden, 1'b0};
		end
		for (int i = 0; i < 4; i++) begin
			side_c.ax_neg[i] = ax_raw[i][15];
			side_c.ax_mag[i] = ax_raw[i][15] ? (~ax_raw[i] + 16'd1) : ax_raw[i];
		end
		for (int j = 0; j < 2; j++) begin
			xx_c[j] = side_c.ax_mag[2*j] * side_c.ax_mag[2*j];
			yy_c[j] = side_c.ax_mag[2*j+1] * side_c.ax_mag[2*j+1];
		end
	end

	side_t            side_s1;
	logic [1:0][31:0] xx_s1;
	logic [1:0][31:0] yy_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_c;
			xx_s1   <= xx_c;
			yy_s1   <= yy_c;
		end
	end

	// ---------------- S2: squared radius ---------------------------------
	side_t      side_s2;
	sq_t [1:0]  sq_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side_s1;
			for (int j = 0; j < 2; j++) begin
				sq_s2[j].src  <= xx_s1[j] + yy_s1[j];
				sq_s2[j].rem  <= '0;
				sq_s2[j].root <= '0;
			end
		end
	end

	// ---------------- S3..S26: magnitude, one root bit per stage ---------
	// The radicand is the squared radius times 65536; its low 16 bits are
	// zero and are shifted in behind the sum.
	sq_t [1:0] sq_s3_26   [SQ_STEPS];
	side_t     side_s3_26 [SQ_STEPS];

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
		for (genvar j = 0; j < 2; j++) begin : g_lane
			if (k == 0) begin : g_first
				gdn_sqrt_step u_step (.clk(clk), .en(en), .d(sq_s2[j]),
					.q(sq_s3_26[k][j]));
			end else begin : g_next
				gdn_sqrt_step u_step (.clk(clk), .en(en), .d(sq_s3_26[k-1][j]),
					.q(sq_s3_26[k][j]));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3_26[0] <= side_s2;
			for (int k = 1; k < SQ_STEPS; k++) begin
				side_s3_26[k] <= side_s3_26[k-1];
			end
		end
	end

	// ---------------- S27: clamp and deadzone compare --------------------
	side_t            side_s27;
	logic [1:0][22:0] m_s27;
	logic [1:0][22:0] d_s27;
	logic [1:0][14:0] kd_s27;
	logic [1:0]       szero_s27;
	logic [3:0][30:0] mk_s27;

	logic [1:0][14:0] dz_c;
	logic [ROOT_W-1:0] m_c;
	logic [22:0]       dzs_c;

	logic [1:0][22:0] m_next;
	logic [1:0][22:0] d_next;
	logic [1:0]       z_next;

	assign dz_c = {right_dz_q, left_dz_q};

	always_ff @(posedge clk) begin
		if (en) begin
			side_s27 <= side_s3_26[SQ_STEPS-1];
			for (int j = 0; j < 2; j++) begin
				kd_s27[j] <= STICK_FULL - dz_c[j];
			end
			for (int i = 0; i < 4; i++) begin
				// Axis magnitude times 32767.
				mk_s27[i] <= {side_s3_26[SQ_STEPS-1].ax_mag[i], 15'b0}
					- 31'(side_s3_26[SQ_STEPS-1].ax_mag[i]);
			end
			m_s27     <= m_next;
			d_s27     <= d_next;
			szero_s27 <= z_next;
		end
	end

	always_comb begin
		m_c   = '0;
		dzs_c = '0;
		for (int j = 0; j < 2; j++) begin
			m_c   = sq_s3_26[SQ_STEPS-1][j].root;
			if (m_c > MAG_CAP) begin
				m_c = MAG_CAP;
			end
			dzs_c     = {dz_c[j], 8'b0};
			m_next[j] = m_c[22:0];
			d_next[j] = m_c[22:0] - dzs_c;
			z_next[j] = (m_c[22:0] <= dzs_c);
		end
	end

	// ---------------- S28: numerator and denominator products -----------
	side_t            side_s28;
	logic [3:0][53:0] num_s28;
	logic [1:0][37:0] den_s28;
	logic [1:0]       szero_s28;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s28  <= side_s27;
			szero_s28 <= szero_s27;
			for (int i = 0; i < 4; i++) begin
				num_s28[i] <= mk_s27[i] * d_s27[i/2];
			end
			for (int j = 0; j < 2; j++) begin
				den_s28[j] <= m_s27[j] * kd_s27[j];
			end
		end
	end

	// ---------------- S29: rounded dividends for six lanes --------------
	// Lanes 0 and 1 are the triggers, lanes 2 to 5 the stick axes.
	dv_t [5:0] dv_s29;
	tail_t     tail_s29;

	always_ff @(posedge clk) begin
		if (en) begin
			tail_s29.buttons <= side_s28.buttons;
			for (int i = 0; i < 2; i++) begin
				dv_s29[i].rem <= DVD_W'(side_s28.tdvd[i]);
				dv_s29[i].dsh <= DSH_W'({side_s28.tdsr[i], 15'b0});
				dv_s29[i].quo <= '0;
				tail_s29.zero[i] <= side_s28.tzero[i];
				tail_s29.neg[i]  <= 1'b0;
			end
			for (int i = 0; i < 4; i++) begin
				dv_s29[i+2].rem <= {num_s28[i], 1'b0} + DVD_W'(den_s28[i/2]);
				dv_s29[i+2].dsh <= {den_s28[i/2], 1'b0, 15'b0};
				dv_s29[i+2].quo <= '0;
				tail_s29.zero[i+2] <= szero_s28[i/2];
				tail_s29.neg[i+2]  <= side_s28.ax_neg[i];
			end
		end
	end

	// ---------------- S30..S45: one quotient bit per stage --------------
	dv_t [5:0] dv_s30_45   [DIV_STEPS];
	tail_t     tail_s30_45 [DIV_STEPS];

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		for (genvar i = 0; i < 6; i++) begin : g_lane
			if (k == 0) begin : g_first
				gdn_div_step u_step (.clk(clk), .en(en), .d(dv_s29[i]),
					.q(dv_s30_45[k][i]));
			end else begin : g_next
				gdn_div_step u_step (.clk(clk), .en(en), .d(dv_s30_45[k-1][i]),
					.q(dv_s30_45[k][i]));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tail_s30_45[0] <= tail_s29;
			for (int k = 1; k < DIV_STEPS; k++) begin
				tail_s30_45[k] <= tail_s30_45[k-1];
			end
		end
	end

	// ---------------- Result: zeroing, saturation, sign ------------------
	res_t             res_c;
	logic [5:0][15:0] lane_c;
	logic [15:0]      sat_c;
	tail_t            tl;

	assign tl = tail_s30_45[DIV_STEPS-1];

	always_comb begin
		sat_c = '0;
		for (int i = 0; i < 6; i++) begin
			sat_c = dv_s30_45[DIV_STEPS-1][i].quo;
			if (i >= 2) begin
				// A full-scale negative axis can reach 32768; clip it.
				if (sat_c > AXIS_MAX) begin
					sat_c = AXIS_MAX;
				end
				if (tl.neg[i]) begin
					sat_c = ~sat_c + 16'd1;
				end
			end
			lane_c[i] = tl.zero[i] ? 16'd0 : sat_c;
		end
		res_c.buttons = tl.buttons;
		res_c.lt      = lane_c[0];
		res_c.rt      = lane_c[1];
		res_c.lx      = lane_c[2];
		res_c.ly      = lane_c[3];
		res_c.rx      = lane_c[4];
		res_c.ry      = lane_c[5];
	end

	// Output register with one skid entry behind it.
	res_t out_q;
	res_t skid_q;
	logic leave;

	assign leave = v_q[NS-1] && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || pad_out.ready) begin
			out_v_q  <= skid_v_q || leave;
			skid_v_q <= 1'b0;
		end else if (leave) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || pad_out.ready) begin
			out_q <= skid_v_q ? skid_q : res_c;
		end else if (leave) begin
			skid_q <= res_c;
		end
	end

	assign pad_out.valid               = out_v_q;
	assign pad_out.button_bits_out     = out_q.buttons;
	assign pad_out.left_trigger_level  = out_q.lt;
	assign pad_out.right_trigger_level = out_q.rt;
	assign pad_out.left_x_out          = out_q.lx;
	assign pad_out.left_y_out          = out_q.ly;
	assign pad_out.right_x_out         = out_q.rx;
	assign pad_out.right_y_out         = out_q.ry;

endmodule
`default_nettype wire

// ----- tb/sv/gamepad_deadzone_normalizer_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gamepad_deadzone_normalizer_tb: self-checking bench of the deadzone normalizer
// Drives raw gamepad samples with random gaps and output stalls, predicts the
// trigger levels and the radially scaled sticks for each accepted sample,
// and compares every result field with the oldest prediction.
// ----------------------------------------------------------------------------
module gamepad_deadzone_normalizer_tb;

	localparam int CFG_TRIGGER = 0;
	localparam int CFG_LEFT    = 1;
	localparam int CFG_RIGHT   = 2;
	localparam int CFG_NONE    = 3;   // unmapped index, the write must be dropped
	localparam int STICK_FULL  = 32767;
	localparam int LIMIT       = 400000;

	typedef struct packed {
		logic [15:0] buttons;
		logic [7:0]  ltrig;
		logic [7:0]  rtrig;
		logic [15:0] lx;
		logic [15:0] ly;
		logic [15:0] rx;
		logic [15:0] ry;
	} sample_t;

	// Seven 16-bit fields in port order, so a check can walk them by index.
	typedef logic [6:0][15:0] pad_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [14:0] cfg_wdata = '0;

	gdn_in_if  pad_in();
	gdn_out_if pad_out();

	gamepad_deadzone_normalizer uut (
		.clk(clk),
		.arst_n(arst_n),
		.pad_in(pad_in),
		.pad_out(pad_out),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	// Deadzone copies that the predictor uses; they only change while idle.
	logic [7:0]  trig_dz  = 8'd30;
	logic [14:0] left_dz  = 15'd7849;
	logic [14:0] right_dz = 15'd8689;

	sample_t     samples_to_send[$];
	pad_result_t expected_results[$];
	bit          hold_sender = 1'b0;
	bit          no_idle = 1'b0;
	int          failures = 0;
	int          cycles = 0;

	// Integer square root, bit by bit, rounded down.
	function automatic longint unsigned floor_root(longint unsigned v);
		longint unsigned res = 0;
		longint unsigned b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// Linear trigger map onto Q0.16, ties rounded up.
	function automatic logic [15:0] trigger_level(logic [7:0] t, logic [7:0] dz);
		longint unsigned num;
		longint unsigned den;
		if (t <= dz)
			return 16'd0;
		num = t - dz;
		den = 255 - dz;
		return 16'((num * 65535 * 2 + den) / (2 * den));
	endfunction

	// One axis scaled by full*(m - dz)/(m*(full - dz)), rounded half away from zero.
	function automatic logic [15:0] scaled_axis(logic signed [15:0] a,
		longint unsigned m, longint unsigned dz);
		longint unsigned mag;
		longint unsigned num;
		longint unsigned den;
		longint unsigned q;
		mag = (a < 0) ? longint'(-int'(a)) : longint'(a);
		num = mag * STICK_FULL * (m - (dz << 8));
		den = m * (STICK_FULL - dz);
		q = (2 * num + den) / (2 * den);
		if (q > STICK_FULL)
			q = STICK_FULL;
		return (a < 0) ? 16'(-q) : 16'(q);
	endfunction

	function automatic void stick_scale(logic signed [15:0] x, logic signed [15:0] y,
		logic [14:0] dz, output logic [15:0] ox, output logic [15:0] oy);
		longint unsigned sq;
		longint unsigned m;
		sq = longint'(int'(x) * int'(x)) + longint'(int'(y) * int'(y));
		m = floor_root(sq << 16);
		if (m > (longint'(STICK_FULL) << 8))
			m = longint'(STICK_FULL) << 8;
		// A deadzone at full scale can never be exceeded by the clamped magnitude.
		if (dz >= STICK_FULL || m <= (longint'(dz) << 8)) begin
			ox = 16'd0;
			oy = 16'd0;
		end else begin
			ox = scaled_axis(x, m, dz);
			oy = scaled_axis(y, m, dz);
		end
	endfunction

	function automatic pad_result_t normalize(sample_t s);
		pad_result_t r;
		r[6] = s.buttons;
		r[5] = trigger_level(s.ltrig, trig_dz);
		r[4] = trigger_level(s.rtrig, trig_dz);
		stick_scale(s.lx, s.ly, left_dz, r[3], r[2]);
		stick_scale(s.rx, s.ry, right_dz, r[1], r[0]);
		return r;
	endfunction

	// Driver: presents queued samples, with random gaps that never withdraw
	// an item that is waiting for ready.
	int send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		bit taken;
		bit go;
		sample_t nxt;
		if (!arst_n) begin
			pad_in.valid <= 1'b0;
		end else begin
			taken = pad_in.valid && pad_in.ready;
			if (taken) begin
				expected_results.push_back(normalize(samples_to_send.pop_front()));
			end
			if (send_gap > 0)
				send_gap--;
			else if (!no_idle && $urandom_range(0, 11) == 0)
				send_gap = $urandom_range(1, 17);
			if (pad_in.valid && !taken)
				go = 1'b1;
			else
				go = !hold_sender && send_gap == 0 && samples_to_send.size() > 0;
			pad_in.valid <= go;
			if (go) begin
				nxt = samples_to_send[0];
				pad_in.button_bits   <= nxt.buttons;
				pad_in.left_trigger  <= nxt.ltrig;
				pad_in.right_trigger <= nxt.rtrig;
				pad_in.left_x        <= nxt.lx;
				pad_in.left_y        <= nxt.ly;
				pad_in.right_x       <= nxt.rx;
				pad_in.right_y       <= nxt.ry;
			end
		end
	end

	// Monitor: stalls the output at random and checks each accepted result.
	int stall_left = 0;
	string field_names[7] = '{"right_y_out", "right_x_out", "left_y_out", "left_x_out",
		"right_trigger_level", "left_trigger_level", "button_bits_out"};
	always @(posedge clk or negedge arst_n) begin
		pad_result_t got;
		pad_result_t want;
		if (!arst_n) begin
			pad_out.ready <= 1'b0;
		end else begin
			if (pad_out.valid && pad_out.ready) begin
				got = {pad_out.button_bits_out, pad_out.left_trigger_level,
					pad_out.right_trigger_level, pad_out.left_x_out, pad_out.left_y_out,
					pad_out.right_x_out, pad_out.right_y_out};
				if (expected_results.size() == 0) begin
					$display("%0t: result with nothing expected: %h", $time, got);
					failures++;
				end else begin
					want = expected_results.pop_front();
					for (int i = 0; i < 7; i++) begin
						if (got[i] !== want[i]) begin
							$display("%0t: %s expected %h actual %h", $time,
								field_names[i], want[i], got[i]);
							failures++;
						end
					end
				end
			end
			if (stall_left > 0)
				stall_left--;
			else if (!no_idle && $urandom_range(0, 11) == 0)
				stall_left = $urandom_range(1, 17);
			pad_out.ready <= (stall_left == 0);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("gamepad_deadzone_normalizer_tb: FAIL");
			$finish;
		end
	end

	task automatic write_reg(int idx, logic [14:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= 2'(idx);
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_TRIGGER: trig_dz  = val[7:0];
			CFG_LEFT:    left_dz  = val;
			CFG_RIGHT:   right_dz = val;
			default:     ;
		endcase
	endtask

	// Waits until all queued samples are in and every result is out, then lets
	// the pipeline settle.
	task automatic drain();
		while (samples_to_send.size() > 0 || expected_results.size() > 0 || pad_in.valid)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	function automatic logic [15:0] near_value(int lim);
		int v;
		v = int'($urandom_range(0, 2 * lim)) - lim;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return 16'(v);
	endfunction

	function automatic logic [15:0] axis_value(int dz);
		case ($urandom_range(0, 5))
			0, 1:    return 16'($urandom);
			2:       return near_value(dz + 400);
			3:       return near_value(dz / 2 + 50);
			4:       return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
			default: return near_value(300);
		endcase
	endfunction

	function automatic sample_t random_sample();
		sample_t s;
		s.buttons = 16'($urandom);
		s.ltrig = $urandom_range(0, 3) == 0 ? 8'(trig_dz + $urandom_range(0, 2)) : 8'($urandom);
		s.rtrig = 8'($urandom);
		s.lx = axis_value(left_dz);
		s.ly = axis_value(left_dz);
		s.rx = axis_value(right_dz);
		s.ry = axis_value(right_dz);
		return s;
	endfunction

	task automatic queue_random(int n);
		for (int i = 0; i < n; i++)
			samples_to_send.push_back(random_sample());
	endtask

	task automatic queue_sample(logic [15:0] b, logic [7:0] lt, logic [7:0] rt,
		logic [15:0] lx, logic [15:0] ly, logic [15:0] rx, logic [15:0] ry);
		samples_to_send.push_back('{b, lt, rt, lx, ly, rx, ry});
	endtask

	initial begin
		pad_in.valid         = 1'b0;
		pad_in.button_bits   = '0;
		pad_in.left_trigger  = '0;
		pad_in.right_trigger = '0;
		pad_in.left_x        = '0;
		pad_in.left_y        = '0;
		pad_in.right_x       = '0;
		pad_in.right_y       = '0;
		pad_out.ready        = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed items with the reset deadzones: field extremes, triggers
		// around the deadzone, stick corners and both sides of the radial edge.
		queue_sample(16'h0000, 8'd0, 8'd255, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		queue_sample(16'hFFFF, 8'd30, 8'd31, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
		queue_sample(16'hA5A5, 8'd255, 8'd29, 16'h8000, 16'h0000, 16'h0000, 16'h8000);
		queue_sample(16'h5A5A, 8'd128, 8'd1, 16'd7849, 16'h0000, 16'd8689, 16'h0000);
		queue_sample(16'h0001, 8'd31, 8'd254, 16'd7850, 16'h0000, 16'd8690, 16'h0000);
		queue_sample(16'h8000, 8'd200, 8'd100, 16'h0000, -16'sd7850, 16'h0000, -16'sd8690);
		queue_sample(16'h1234, 8'd60, 8'd61, 16'd5550, 16'd5551, 16'd6144, 16'd6145);
		queue_sample(16'hFEDC, 8'd255, 8'd0, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
		queue_sample(16'h0F0F, 8'd16, 8'd240, 16'd23170, 16'd23170, -16'sd23170, 16'd23170);
		queue_sample(16'hF0F0, 8'd32, 8'd33, 16'd1, -16'sd1, 16'd32767, 16'd1);
		queue_random(10);
		drain();

		// Every deadzone at zero: everything but a zero sample passes.
		write_reg(CFG_TRIGGER, 15'd0);
		write_reg(CFG_LEFT, 15'd0);
		write_reg(CFG_RIGHT, 15'd0);
		queue_sample(16'h0000, 8'd0, 8'd1, 16'h0000, 16'h0001, 16'h8000, 16'h0000);
		queue_sample(16'hFFFF, 8'd255, 8'd128, 16'h8000, 16'h8000, 16'h0001, 16'h0001);
		queue_random(180);
		// Hold the sender halfway until the pipeline has emptied.
		wait (samples_to_send.size() < 90);
		hold_sender = 1'b1;
		while (expected_results.size() > 0 || pad_in.valid)
			@(posedge clk);
		hold_sender = 1'b0;
		drain();

		// Largest legal deadzones.
		write_reg(CFG_TRIGGER, 15'd254);
		write_reg(CFG_LEFT, 15'd32766);
		write_reg(CFG_RIGHT, 15'd32766);
		queue_sample(16'h00FF, 8'd255, 8'd254, 16'h8000, 16'h0000, 16'h7FFF, 16'h7FFF);
		queue_random(150);
		drain();

		// Deadzones at full scale through the low bits of the write data:
		// triggers and sticks must always give zero. A write to the unmapped
		// index must change nothing.
		write_reg(CFG_TRIGGER, 15'h7FFF);
		write_reg(CFG_LEFT, 15'd32767);
		write_reg(CFG_RIGHT, 15'd32767);
		write_reg(CFG_NONE, 15'd5);
		queue_sample(16'hFFFF, 8'd255, 8'd255, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000);
		queue_random(150);
		drain();

		for (int p = 0; p < 3; p++) begin
			write_reg(CFG_TRIGGER, 15'($urandom_range(0, 255)) | 15'(p << 8));
			write_reg(CFG_LEFT, 15'($urandom_range(0, 32767)));
			write_reg(CFG_RIGHT, 15'($urandom_range(0, 20000)));
			write_reg(CFG_NONE, 15'($urandom));
			queue_random(170);
			drain();
		end

		// Back to typical deadzones, with neither side idling.
		write_reg(CFG_TRIGGER, 15'd30);
		write_reg(CFG_LEFT, 15'd7849);
		write_reg(CFG_RIGHT, 15'd8689);
		no_idle = 1'b1;
		queue_random(150);
		drain();

		if (failures == 0)
			$display("gamepad_deadzone_normalizer_tb: PASS");
		else
			$display("gamepad_deadzone_normalizer_tb: FAIL");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/gdn_pkg.sv
rtl/gdn_in_if.sv
rtl/gdn_out_if.sv
rtl/gdn_sqrt_step.sv
rtl/gdn_div_step.sv
rtl/gamepad_deadzone_normalizer.sv
tb/sv/gamepad_deadzone_normalizer_tb.sv
